@@ design/ezr_pkg.sv @@
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared constants, types and helper functions for the ZYX rotation core.
// ----------------------------------------------------------------------------
package ezr_pkg;

	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int ENTRY_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 32;

	// internal Q30 datapath; CORDIC values stay well under 2^32
	localparam int QW = 34;
	typedef logic signed [QW-1:0] q30_t;

	localparam logic signed [QW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [QW-1:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [QW-1:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [QW-1:0] HALF_Q30 = 34'sd1686629713;

	// atan(2^-i) in Q30, rounded to nearest
	function automatic q30_t atan_q30(input int i);
		q30_t r;
		case (i)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			24: r = 34'sd64;
			25: r = 34'sd32;
			26: r = 34'sd16;
			27: r = 34'sd8;
			28: r = 34'sd4;
			29: r = 34'sd2;
			30: r = 34'sd1;
			31: r = 34'sd1;   // half an LSB, rounds up
			default: r = '0;
		endcase
		return r;
	endfunction

	// one CORDIC lane: x, y, residual angle, flip flag
	typedef struct packed {
		q30_t x;
		q30_t y;
		q30_t z;
		logic flip;
	} lane_t;

	function automatic q30_t clamp_one(input q30_t v);
		q30_t r;
		if (v > ONE_Q30) r = ONE_Q30;
		else if (v < -ONE_Q30) r = -ONE_Q30;
		else r = v;
		return r;
	endfunction

	// product of two Q30 values, rounded half up back to Q30
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [2*QW-1:0] p;
		p = a * b + (68'sd1 <<< 29);
		return q30_t'(p >>> 30);
	endfunction

endpackage

@@ design/ezr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ezr_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface ezr_stream_if #(parameter int W = 48);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/ezr_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ezr_cordic_cell
// One CORDIC rotation step for three angles, registered, stallable.
// ----------------------------------------------------------------------------
module ezr_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  ezr_pkg::lane_t [2:0] lin,
	output logic                 vout,
	output ezr_pkg::lane_t [2:0] lout
);
	localparam ezr_pkg::q30_t ATAN = ezr_pkg::atan_q30(STAGE);
	ezr_pkg::lane_t [2:0] nxt;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].flip = lin[k].flip;
			if (!lin[k].z[ezr_pkg::QW-1]) begin
				nxt[k].x = lin[k].x - (lin[k].y >>> STAGE);
				nxt[k].y = lin[k].y + (lin[k].x >>> STAGE);
				nxt[k].z = lin[k].z - ATAN;
			end else begin
				nxt[k].x = lin[k].x + (lin[k].y >>> STAGE);
				nxt[k].y = lin[k].y - (lin[k].x >>> STAGE);
				nxt[k].z = lin[k].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) lout <= nxt;
	end
endmodule

@@ design/euler_zyx_to_rotation_core.sv @@
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_core
// Roll/pitch/yaw (Q3.13) to ZYX rotation matrix (Q2.14) through CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//  - in_req (sink): {yaw, pitch, roll}, ANGLE_WIDTH bits each, roll at LSB.
//  - out_rsp (source): nine entries r00..r22, r00 at the LSB.
//  - A request is taken when valid and ready are both high.
//  - Pipeline: 1 input stage (saturate, quadrant fold), CORDIC_STAGES cells,
//    1 sin/cos unfold stage, 2 product stages, 1 sum/round output stage.
//    One request per cycle is sustained while out_rsp does not stall.
//  - Each CORDIC cell rotates all three angles by one step and hands its lanes
//    to the next cell on every cycle that the pipe advances.
//  - The whole pipe advances together: when out_rsp stalls with its output
//    register full, every stage holds and in_req.ready drops. A full output
//    register with ready high drains and refills in the same cycle.
//  - Reset clears all valid flags; no state survives between requests.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_core #(
	parameter int ANGLE_WIDTH   = ezr_pkg::ANGLE_WIDTH_DEF,
	parameter int ENTRY_WIDTH   = ezr_pkg::ENTRY_WIDTH_DEF,
	parameter int CORDIC_STAGES = ezr_pkg::CORDIC_STAGES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ezr_stream_if.sink   in_req,
	ezr_stream_if.source out_rsp
);
	localparam int AFRAC = ANGLE_WIDTH - 3;
	localparam int EFRAC = ENTRY_WIDTH - 2;
	localparam int ESH = 30 - EFRAC;

	typedef logic signed [ANGLE_WIDTH-1:0] ang_t;
	typedef ezr_pkg::q30_t q_t;

	// pipe advances unless output register holds an untaken result
	logic en;
	assign en = !out_rsp.valid || out_rsp.ready;
	assign in_req.ready = en;

	// ---- stage 0: saturate, scale to Q30, fold to +/- pi/2
	localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;
	localparam logic [63:0] LIM_U =
		(PI_Q60 + (64'd1 << (59 - AFRAC))) >> (60 - AFRAC);
	localparam q_t LIM = q_t'(LIM_U);

	ezr_pkg::lane_t [2:0] lane0;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q_t a;
			a = q_t'(ang_t'(in_req.data[k*ANGLE_WIDTH +: ANGLE_WIDTH]));
			if (a > LIM) a = LIM;
			else if (a < -LIM) a = -LIM;
			a = a <<< (30 - AFRAC);
			lane0[k].x = ezr_pkg::GAIN_Q30;
			lane0[k].y = '0;
			if (a > ezr_pkg::HALF_Q30) begin
				lane0[k].z = a - ezr_pkg::PI_Q30;
				lane0[k].flip = 1'b1;
			end else if (a < -ezr_pkg::HALF_Q30) begin
				lane0[k].z = a + ezr_pkg::PI_Q30;
				lane0[k].flip = 1'b1;
			end else begin
				lane0[k].z = a;
				lane0[k].flip = 1'b0;
			end
		end
	end

	logic                 v_s1;
	ezr_pkg::lane_t [2:0] l_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_req.valid;
	end
	always_ff @(posedge clk) begin
		if (en) l_s1 <= lane0;
	end

	// ---- CORDIC chain
	logic                 cv [CORDIC_STAGES+1];
	ezr_pkg::lane_t [2:0] cl [CORDIC_STAGES+1];
	assign cv[0] = v_s1;
	assign cl[0] = l_s1;
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ezr_cordic_cell #(.STAGE(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(cv[i]), .lin(cl[i]), .vout(cv[i+1]), .lout(cl[i+1])
		);
	end

	// ---- unfold and clamp: c/s for roll, pitch, yaw
	logic v_s2;
	q_t   c_s2 [3];
	q_t   s_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= cv[CORDIC_STAGES];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				q_t x, y;
				x = cl[CORDIC_STAGES][k].x;
				y = cl[CORDIC_STAGES][k].y;
				if (cl[CORDIC_STAGES][k].flip) begin
					x = -x;
					y = -y;
				end
				c_s2[k] <= ezr_pkg::clamp_one(x);
				s_s2[k] <= ezr_pkg::clamp_one(y);
			end
		end
	end

	// ---- first products (index 0 roll, 1 pitch, 2 yaw)
	logic v_s3;
	q_t   cysp_s3, sysp_s3, cycp_s3, sycp_s3, sycr_s3, sysr_s3;
	q_t   cycr_s3, cysr_s3, cpsr_s3, cpcr_s3, sp_s3, sr_s3, cr_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s3 <= ezr_pkg::mul_q30(c_s2[2], s_s2[1]);
			sysp_s3 <= ezr_pkg::mul_q30(s_s2[2], s_s2[1]);
			cycp_s3 <= ezr_pkg::mul_q30(c_s2[2], c_s2[1]);
			sycp_s3 <= ezr_pkg::mul_q30(s_s2[2], c_s2[1]);
			sycr_s3 <= ezr_pkg::mul_q30(s_s2[2], c_s2[0]);
			sysr_s3 <= ezr_pkg::mul_q30(s_s2[2], s_s2[0]);
			cycr_s3 <= ezr_pkg::mul_q30(c_s2[2], c_s2[0]);
			cysr_s3 <= ezr_pkg::mul_q30(c_s2[2], s_s2[0]);
			cpsr_s3 <= ezr_pkg::mul_q30(c_s2[1], s_s2[0]);
			cpcr_s3 <= ezr_pkg::mul_q30(c_s2[1], c_s2[0]);
			sp_s3   <= s_s2[1];
			sr_s3   <= s_s2[0];
			cr_s3   <= c_s2[0];
		end
	end

	// ---- second products; plain terms pass along
	logic v_s4;
	q_t   e_s4 [9];
	q_t   g_s4 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			e_s4[0] <= cycp_s3;
			e_s4[1] <= ezr_pkg::mul_q30(cysp_s3, sr_s3);
			e_s4[2] <= ezr_pkg::mul_q30(cysp_s3, cr_s3);
			e_s4[3] <= sycp_s3;
			e_s4[4] <= ezr_pkg::mul_q30(sysp_s3, sr_s3);
			e_s4[5] <= ezr_pkg::mul_q30(sysp_s3, cr_s3);
			e_s4[6] <= -sp_s3;
			e_s4[7] <= cpsr_s3;
			e_s4[8] <= cpcr_s3;
			g_s4[0] <= sycr_s3;
			g_s4[1] <= sysr_s3;
			g_s4[2] <= cycr_s3;
			g_s4[3] <= cysr_s3;
		end
	end

	// ---- sums, round to entry format, clamp: output register
	localparam q_t ELIM = q_t'(64'd1 << EFRAC);
	q_t pre [9];
	always_comb begin
		for (int k = 0; k < 9; k++) pre[k] = e_s4[k];
		pre[1] = e_s4[1] - g_s4[0];
		pre[2] = e_s4[2] + g_s4[1];
		pre[4] = e_s4[4] + g_s4[2];
		pre[5] = e_s4[5] - g_s4[3];
	end

	logic [9*ENTRY_WIDTH-1:0] ent;
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			q_t v;
			v = pre[k];
			if (ESH > 0) v = (v + (q_t'(1) <<< (ESH - 1))) >>> ESH;
			if (v > ELIM) v = ELIM;
			else if (v < -ELIM) v = -ELIM;
			ent[k*ENTRY_WIDTH +: ENTRY_WIDTH] = v[ENTRY_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_rsp.valid <= 1'b0;
		else if (en) out_rsp.valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) out_rsp.data <= ent;
	end

`ifndef SYNTHESIS
	// stalled output holds its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.data))
		else $error("output changed while stalled");
	// ready follows output occupancy
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_req.ready == (!out_rsp.valid || out_rsp.ready))
		else $error("ready mismatch");
	// an advancing request in the input stage register enters the first CORDIC cell
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 |=> cv[1])
		else $error("cordic chain lost a request");
`endif
endmodule
